### design/breath_cycle_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// Breath cycle sequencer assertion macros
// Concurrent check wrappers; empty bodies in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BREATH_CYCLE_SEQUENCER_CORE_DEFINES_SVH
`define BREATH_CYCLE_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check held off while reset is asserted
`define BCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also runs during reset
`define BCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/bcs_pkg.sv
// ----------------------------------------------------------------------------
// Breath cycle sequencer package
// Phase, command and register codes, widths and reset values.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int PEEP_HYST  = 8;

  localparam int PW = 12;  // pressure width
  localparam int CW = 14;  // width for threshold compares

  // recruitment hysteresis: +2 cmH2O / -0.5 cmH2O in 1/16 cmH2O
  localparam logic signed [CW-1:0] RECRUIT_UP   = CW'(32);
  localparam logic signed [CW-1:0] RECRUIT_DOWN = CW'(8);
  localparam logic signed [CW-1:0] PEEP_HYST_C  = CW'(PEEP_HYST);

  typedef enum logic [2:0] {
    PH_HOMING   = 3'd0,
    PH_INIT_INS = 3'd1,
    PH_INS      = 3'd2,
    PH_INIT_EXS = 3'd3,
    PH_EXS      = 3'd4,
    PH_ERROR    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_RECRUIT_ON  = 2'd1,
    CMD_RECRUIT_OFF = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MOT_NONE = 2'd0,
    MOT_HIGH = 2'd1,
    MOT_LOW  = 2'd2,
    MOT_STOP = 2'd3
  } motor_e;

  typedef enum logic [1:0] {
    VOL_NONE       = 2'd0,
    VOL_RESET      = 2'd1,
    VOL_SAVE_RESET = 2'd2
  } volume_e;

  typedef enum logic [2:0] {
    CFG_INSP_TICKS      = 3'd0,
    CFG_EXP_TICKS       = 3'd1,
    CFG_RECRUIT_TICKS   = 3'd2,
    CFG_TARGET_PIP      = 3'd3,
    CFG_TARGET_PEEP     = 3'd4,
    CFG_RECRUIT_PIP     = 3'd5,
    CFG_ALARM_PRESSURE  = 3'd6,
    CFG_RELIEF_PRESSURE = 3'd7
  } cfg_idx_e;

  localparam logic [15:0]          RST_INSP_TICKS    = 16'd100;
  localparam logic [15:0]          RST_EXP_TICKS     = 16'd200;
  localparam logic [15:0]          RST_RECRUIT_TICKS = 16'd400;
  localparam logic signed [PW-1:0] RST_TARGET_PIP    = 12'sd320;
  localparam logic signed [PW-1:0] RST_TARGET_PEEP   = 12'sd80;
  localparam logic signed [PW-1:0] RST_RECRUIT_PIP   = 12'sd640;
  localparam logic signed [PW-1:0] RST_ALARM_PRESS   = 12'sd960;
  localparam logic signed [PW-1:0] RST_RELIEF_PRESS  = 12'sd1040;

  function automatic logic signed [CW-1:0] sx(input logic signed [PW-1:0] v);
    return {{(CW-PW){v[PW-1]}}, v};
  endfunction

endpackage

### design/breath_cycle_sequencer_core.sv
// ----------------------------------------------------------------------------
// Breath cycle sequencer core
// Homing / insufflation / exsufflation phase sequencer with valve hysteresis,
// overpressure alarm and PID / motor / volume command generation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o | cmd, pressure, sensor_ok, endstop
//  out     | output    | out_valid_o/out_stall_i | phase ... sensor_error
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
//  One beat per clock while in_stall_o is low: state and result register load
//  at the edge that accepts the input beat, result visible the next cycle.
//  The result register is the only buffer; in_stall_o rises only while a
//  result is held and the sink stalls, so a beat enters every cycle otherwise.
//  rst_ni (async, active low) returns to homing with the documented
//  register defaults and an empty result register.
// ----------------------------------------------------------------------------
`include "breath_cycle_sequencer_core_defines.svh"

module breath_cycle_sequencer_core
  import bcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic signed [PW-1:0] pressure_i,
  input  logic                 sensor_ok_i,
  input  logic                 endstop_open_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           phase_o,
  output logic                 valve_open_o,
  output logic                 alarm_over_o,
  output logic signed [PW-1:0] pid_setpoint_o,
  output logic                 pid_enable_o,
  output logic                 pid_clear_o,
  output logic [1:0]           motor_command_o,
  output logic [1:0]           volume_command_o,
  output logic                 homing_request_o,
  output logic                 sensor_error_o
);

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]          insp_ticks_q, exp_ticks_q, recruit_ticks_q;
  logic signed [PW-1:0] target_pip_q, target_peep_q, recruit_pip_q;
  logic signed [PW-1:0] alarm_press_q, relief_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insp_ticks_q    <= RST_INSP_TICKS;
      exp_ticks_q     <= RST_EXP_TICKS;
      recruit_ticks_q <= RST_RECRUIT_TICKS;
      target_pip_q    <= RST_TARGET_PIP;
      target_peep_q   <= RST_TARGET_PEEP;
      recruit_pip_q   <= RST_RECRUIT_PIP;
      alarm_press_q   <= RST_ALARM_PRESS;
      relief_press_q  <= RST_RELIEF_PRESS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INSP_TICKS:      insp_ticks_q    <= cfg_data_i;
        CFG_EXP_TICKS:       exp_ticks_q     <= cfg_data_i;
        CFG_RECRUIT_TICKS:   recruit_ticks_q <= cfg_data_i;
        CFG_TARGET_PIP:      target_pip_q    <= cfg_data_i[PW-1:0];
        CFG_TARGET_PEEP:     target_peep_q   <= cfg_data_i[PW-1:0];
        CFG_RECRUIT_PIP:     recruit_pip_q   <= cfg_data_i[PW-1:0];
        CFG_ALARM_PRESSURE:  alarm_press_q   <= cfg_data_i[PW-1:0];
        CFG_RELIEF_PRESSURE: relief_press_q  <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic in_accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  phase_e                phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [TICK_WIDTH-1:0] limit_q, limit_d;
  logic                  recruit_q, recruit_d;
  logic                  valve_q, valve_d;
  logic                  alarm_q, alarm_d;

  // per-beat command outputs
  logic signed [PW-1:0]  setpoint;
  logic                  pid_en, pid_clr, homing, err;
  motor_e                motor;
  volume_e               volume;

  // widened compare operands
  logic signed [CW-1:0]  p_w;
  logic                  expired;

  assign p_w     = sx(pressure_i);
  assign expired = (tick_q > limit_q) || (tick_q == TICK_MAX);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    limit_d   = limit_q;
    recruit_d = recruit_q;
    valve_d   = valve_q;
    alarm_d   = alarm_q;
    setpoint  = '0;
    pid_en    = 1'b0;
    pid_clr   = 1'b0;
    homing    = 1'b0;
    err       = 1'b0;
    motor     = MOT_NONE;
    volume    = VOL_NONE;

    case (cmd_e'(cmd_i))
      CMD_RECRUIT_ON: begin
        recruit_d = 1'b1;
        phase_d   = PH_INIT_INS;
      end
      CMD_RECRUIT_OFF: begin
        recruit_d = 1'b0;
        phase_d   = PH_INIT_EXS;
      end
      CMD_TICK: begin
        // sensor fault overrides the current phase, even homing
        err = ~sensor_ok_i;
        if (err) phase_d = PH_EXS;
        alarm_d = p_w > sx(alarm_press_q);
        if (p_w > sx(relief_press_q)) valve_d = 1'b1;

        case (phase_d)
          PH_HOMING: begin
            valve_d = 1'b1;
            homing  = endstop_open_i;
            tick_d  = '0;
            phase_d = PH_INIT_EXS;
          end
          PH_INIT_INS: begin
            valve_d = 1'b0;
            volume  = VOL_RESET;
            limit_d = TICK_WIDTH'(recruit_q ? recruit_ticks_q : insp_ticks_q);
            motor   = MOT_HIGH;
            pid_clr = 1'b1;
            phase_d = PH_INS;
            tick_d  = '0;
          end
          PH_INS: begin
            if (expired) begin
              motor     = MOT_STOP;
              phase_d   = PH_INIT_EXS;
              tick_d    = '0;
              recruit_d = 1'b0;
            end else begin
              pid_en   = 1'b1;
              setpoint = recruit_q ? recruit_pip_q : target_pip_q;
              if (recruit_q) begin
                if (p_w > sx(recruit_pip_q) + RECRUIT_UP) valve_d = 1'b1;
                else if (p_w < sx(recruit_pip_q) - RECRUIT_DOWN) valve_d = 1'b0;
              end
              if (tick_q != TICK_MAX) tick_d = tick_q + TICK_WIDTH'(1);
            end
          end
          PH_INIT_EXS: begin
            valve_d = 1'b1;
            limit_d = TICK_WIDTH'(exp_ticks_q);
            volume  = VOL_SAVE_RESET;
            motor   = MOT_LOW;
            pid_clr = 1'b1;
            phase_d = PH_EXS;
            tick_d  = '0;
          end
          PH_EXS: begin
            if (expired) begin
              motor   = MOT_STOP;
              phase_d = PH_INIT_INS;
              tick_d  = '0;
            end else begin
              pid_en   = 1'b1;
              setpoint = target_peep_q;
              if (p_w <= sx(target_peep_q) - PEEP_HYST_C) valve_d = 1'b0;
              else if (p_w > sx(target_peep_q) + PEEP_HYST_C) valve_d = 1'b1;
              if (tick_q != TICK_MAX) tick_d = tick_q + TICK_WIDTH'(1);
            end
          end
          default: ;  // error phase: only the checks above
        endcase
      end
      default: ;  // unused command code: no state change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HOMING;
      tick_q    <= '0;
      limit_q   <= '0;
      recruit_q <= 1'b0;
      valve_q   <= 1'b0;
      alarm_q   <= 1'b0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      limit_q   <= limit_d;
      recruit_q <= recruit_d;
      valve_q   <= valve_d;
      alarm_q   <= alarm_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [2:0]           out_phase_q;
  logic                 out_valve_q, out_alarm_q;
  logic signed [PW-1:0] out_setpoint_q;
  logic                 out_pid_en_q, out_pid_clr_q, out_homing_q, out_err_q;
  logic [1:0]           out_motor_q, out_volume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_phase_q    <= phase_d;
      out_valve_q    <= valve_d;
      out_alarm_q    <= alarm_d;
      out_setpoint_q <= setpoint;
      out_pid_en_q   <= pid_en;
      out_pid_clr_q  <= pid_clr;
      out_motor_q    <= motor;
      out_volume_q   <= volume;
      out_homing_q   <= homing;
      out_err_q      <= err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = out_phase_q;
  assign valve_open_o     = out_valve_q;
  assign alarm_over_o     = out_alarm_q;
  assign pid_setpoint_o   = out_setpoint_q;
  assign pid_enable_o     = out_pid_en_q;
  assign pid_clear_o      = out_pid_clr_q;
  assign motor_command_o  = out_motor_q;
  assign volume_command_o = out_volume_q;
  assign homing_request_o = out_homing_q;
  assign sensor_error_o   = out_err_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // input side only backs up while a result is held
  `BCS_ASSERT_ALWAYS(a_stall_needs_result, clk_i, (in_stall_o |-> out_valid_q), "stall without held result")
  // a running PID beat never carries a motor or volume command
  `BCS_ASSERT(a_pid_exclusive, clk_i, rst_ni, (out_valid_q && out_pid_en_q |-> out_motor_q == MOT_NONE && out_volume_q == VOL_NONE && !out_pid_clr_q), "pid beat with motion command")
  // a sensor fault always lands in exsufflation or its timeout successor
  `BCS_ASSERT(a_err_phase, clk_i, rst_ni, (out_valid_q && out_err_q |-> out_phase_q == PH_EXS || out_phase_q == PH_INIT_INS), "sensor error left wrong phase")

endmodule

### tb/sv/tb_breath_cycle_sequencer_core.sv
// ----------------------------------------------------------------------------
// Breath cycle sequencer core testbench
// Drives ticks and recruitment commands through the input channel and checks
// every result beat against a cycle-free predictor of the phase sequencer.
// A directed table comes first, then random traffic under several register
// settings, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_breath_cycle_sequencer_core
  import bcs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Recruitment valve band: open above target + 2 cmH2O, close below
  // target - 0.5 cmH2O (1/16 cmH2O units).
  localparam int RECRUIT_OPEN_MARGIN  = 32;
  localparam int RECRUIT_CLOSE_MARGIN = 8;

  localparam longint unsigned TICK_ALL_ONES = (64'd1 << TICK_WIDTH) - 1;

  localparam int RANDOM_BEATS = 225;   // per register setting
  localparam int QUIET_LIMIT  = 2000;  // cycles without any beat moving
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [PW-1:0] pressure;
    logic                 sensor_ok;
    logic                 endstop_open;
  } vent_beat_t;

  typedef struct packed {
    logic [2:0]           phase;
    logic                 valve_open;
    logic                 alarm_over;
    logic signed [PW-1:0] pid_setpoint;
    logic                 pid_enable;
    logic                 pid_clear;
    logic [1:0]           motor_command;
    logic [1:0]           volume_command;
    logic                 homing_request;
    logic                 sensor_error;
  } vent_result_t;

  // One directed row; want is only used when typed is set.
  typedef struct {
    vent_beat_t   beat;
    bit           typed;
    vent_result_t want;
  } dir_row_t;

  typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_e;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [2:0]           cfg_index_i    = CFG_INSP_TICKS;
  logic [15:0]          cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           cmd_i          = CMD_TICK;
  logic signed [PW-1:0] pressure_i     = '0;
  logic                 sensor_ok_i    = 1'b1;
  logic                 endstop_open_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [2:0]           phase_o;
  logic                 valve_open_o;
  logic                 alarm_over_o;
  logic signed [PW-1:0] pid_setpoint_o;
  logic                 pid_enable_o;
  logic                 pid_clear_o;
  logic [1:0]           motor_command_o;
  logic [1:0]           volume_command_o;
  logic                 homing_request_o;
  logic                 sensor_error_o;

  breath_cycle_sequencer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .pressure_i       (pressure_i),
    .sensor_ok_i      (sensor_ok_i),
    .endstop_open_i   (endstop_open_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .phase_o          (phase_o),
    .valve_open_o     (valve_open_o),
    .alarm_over_o     (alarm_over_o),
    .pid_setpoint_o   (pid_setpoint_o),
    .pid_enable_o     (pid_enable_o),
    .pid_clear_o      (pid_clear_o),
    .motor_command_o  (motor_command_o),
    .volume_command_o (volume_command_o),
    .homing_request_o (homing_request_o),
    .sensor_error_o   (sensor_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Sequencer predictor: own copy of the registers and of the state
  // --------------------------------------------------------------------------
  longint unsigned m_insp_len, m_exhale_len, m_recruit_len;
  int              m_pip, m_peep, m_rpip, m_alarm_lvl, m_relief_lvl;
  phase_e          m_phase;
  longint unsigned m_ticks, m_limit;
  bit              m_recruit, m_valve, m_alarm;

  vent_result_t    due_results[$];

  int n_beats, n_results, n_errors, n_settings, n_stops, n_sensor_errs;

  function automatic void reset_model();
    m_insp_len    = RST_INSP_TICKS;
    m_exhale_len  = RST_EXP_TICKS;
    m_recruit_len = RST_RECRUIT_TICKS;
    m_pip         = RST_TARGET_PIP;
    m_peep        = RST_TARGET_PEEP;
    m_rpip        = RST_RECRUIT_PIP;
    m_alarm_lvl   = RST_ALARM_PRESS;
    m_relief_lvl  = RST_RELIEF_PRESS;
    m_phase       = PH_HOMING;
    m_ticks       = 0;
    m_limit       = 0;
    m_recruit     = 1'b0;
    m_valve       = 1'b0;
    m_alarm       = 1'b0;
  endfunction

  // 16-bit registers keep all bits, pressure registers only the low 12
  function automatic void load_setting(input cfg_idx_e idx, input logic [15:0] d);
    case (idx)
      CFG_INSP_TICKS:      m_insp_len    = d;
      CFG_EXP_TICKS:       m_exhale_len  = d;
      CFG_RECRUIT_TICKS:   m_recruit_len = d;
      CFG_TARGET_PIP:      m_pip         = $signed(d[PW-1:0]);
      CFG_TARGET_PEEP:     m_peep        = $signed(d[PW-1:0]);
      CFG_RECRUIT_PIP:     m_rpip        = $signed(d[PW-1:0]);
      CFG_ALARM_PRESSURE:  m_alarm_lvl   = $signed(d[PW-1:0]);
      CFG_RELIEF_PRESSURE: m_relief_lvl  = $signed(d[PW-1:0]);
      default: ;
    endcase
  endfunction

  // a saturated counter ends the phase even at the largest limit
  function automatic bit timed_out();
    return (m_ticks > m_limit) || (m_ticks == TICK_ALL_ONES);
  endfunction

  function automatic void bump_ticks();
    if (m_ticks < TICK_ALL_ONES) m_ticks++;
  endfunction

  function automatic vent_result_t step_model(input vent_beat_t b);
    vent_result_t r;
    int           p;
    r = '0;
    p = $signed(b.pressure);
    case (b.cmd)
      CMD_RECRUIT_ON: begin
        m_recruit = 1'b1;
        m_phase   = PH_INIT_INS;
      end
      CMD_RECRUIT_OFF: begin
        // also taken when recruitment was never entered
        m_recruit = 1'b0;
        m_phase   = PH_INIT_EXS;
      end
      CMD_TICK: begin
        // sensor fault wins over everything, homing included
        r.sensor_error = !b.sensor_ok;
        if (!b.sensor_ok) m_phase = PH_EXS;
        m_alarm = (p > m_alarm_lvl);
        if (p > m_relief_lvl) m_valve = 1'b1;
        case (m_phase)
          PH_HOMING: begin
            m_valve            = 1'b1;
            r.homing_request   = b.endstop_open;
            m_ticks            = 0;
            m_phase            = PH_INIT_EXS;
          end
          PH_INIT_INS: begin
            m_valve            = 1'b0;
            r.volume_command   = VOL_RESET;
            m_limit            = m_recruit ? m_recruit_len : m_insp_len;
            r.motor_command    = MOT_HIGH;
            r.pid_clear        = 1'b1;
            m_phase            = PH_INS;
            m_ticks            = 0;
          end
          PH_INS: begin
            if (timed_out()) begin
              r.motor_command = MOT_STOP;
              m_phase         = PH_INIT_EXS;
              m_ticks         = 0;
              m_recruit       = 1'b0;
            end else begin
              r.pid_enable   = 1'b1;
              r.pid_setpoint = PW'(m_recruit ? m_rpip : m_pip);
              if (m_recruit) begin
                if (p > m_rpip + RECRUIT_OPEN_MARGIN) m_valve = 1'b1;
                else if (p < m_rpip - RECRUIT_CLOSE_MARGIN) m_valve = 1'b0;
              end
              bump_ticks();
            end
          end
          PH_INIT_EXS: begin
            m_valve            = 1'b1;
            m_limit            = m_exhale_len;
            r.volume_command   = VOL_SAVE_RESET;
            r.motor_command    = MOT_LOW;
            r.pid_clear        = 1'b1;
            m_phase            = PH_EXS;
            m_ticks            = 0;
          end
          PH_EXS: begin
            if (timed_out()) begin
              r.motor_command = MOT_STOP;
              m_phase         = PH_INIT_INS;
              m_ticks         = 0;
            end else begin
              r.pid_enable   = 1'b1;
              r.pid_setpoint = PW'(m_peep);
              // PEEP band: close at or below the low edge, open above the high
              if (p <= m_peep - PEEP_HYST) m_valve = 1'b0;
              else if (p > m_peep + PEEP_HYST) m_valve = 1'b1;
              bump_ticks();
            end
          end
          default: ;  // error phase: only the checks above
        endcase
      end
      default: ;      // unused command code: no state change
    endcase
    r.phase      = m_phase;
    r.valve_open = m_valve;
    r.alarm_over = m_alarm;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic vent_result_t res(input phase_e ph, input bit v, input bit a,
                                       input int sp, input bit en, input bit clr,
                                       input motor_e mot, input volume_e vol,
                                       input bit hom, input bit err);
    vent_result_t r;
    r.phase          = ph;
    r.valve_open     = v;
    r.alarm_over     = a;
    r.pid_setpoint   = PW'(sp);
    r.pid_enable     = en;
    r.pid_clear      = clr;
    r.motor_command  = mot;
    r.volume_command = vol;
    r.homing_request = hom;
    r.sensor_error   = err;
    return r;
  endfunction

  function automatic dir_row_t row(input logic [1:0] cmd, input int p, input bit ok,
                                   input bit es);
    dir_row_t d;
    d.beat.cmd          = cmd;
    d.beat.pressure     = p[PW-1:0];
    d.beat.sensor_ok    = ok;
    d.beat.endstop_open = es;
    d.typed             = 1'b0;
    d.want              = '0;
    return d;
  endfunction

  function automatic dir_row_t trow(input logic [1:0] cmd, input int p, input bit ok,
                                    input bit es, input vent_result_t want);
    dir_row_t d;
    d       = row(cmd, p, ok, es);
    d.typed = 1'b1;
    d.want  = want;
    return d;
  endfunction

  function automatic int any_pressure();
    int v;
    v = $urandom_range(0, 4095);
    return v - 2048;
  endfunction

  // Mostly lands on the edges of the current thresholds, clamped to 12 bits.
  function automatic int pick_pressure();
    int p;
    int jit;
    jit = $urandom_range(0, 4);
    jit -= 2;
    case ($urandom_range(0, 7))
      0:       p = m_peep - PEEP_HYST + jit;
      1:       p = m_peep + PEEP_HYST + jit;
      2:       p = m_rpip + RECRUIT_OPEN_MARGIN + jit;
      3:       p = m_rpip - RECRUIT_CLOSE_MARGIN + jit;
      4:       p = m_alarm_lvl + jit;
      5:       p = m_relief_lvl + jit;
      6:       p = any_pressure();
      default: p = $urandom_range(0, 800);
    endcase
    if (p > 2047) p = 2047;
    if (p < -2048) p = -2048;
    return p;
  endfunction

  function automatic vent_beat_t random_beat();
    int         sel;
    logic [1:0] cmd;
    dir_row_t   d;
    sel = $urandom_range(0, 99);
    if (sel < 4)       cmd = CMD_RECRUIT_ON;
    else if (sel < 8)  cmd = CMD_RECRUIT_OFF;
    else if (sel < 10) cmd = CMD_UNUSED;
    else               cmd = CMD_TICK;
    d = row(cmd, pick_pressure(), $urandom_range(0, 39) != 0,
            $urandom_range(0, 1) == 1);
    return d.beat;
  endfunction

  function automatic string show(input vent_result_t r);
    return $sformatf({"phase=%0d valve=%0b alarm=%0b setpoint=%0d pid_en=%0b ",
                      "pid_clr=%0b motor=%0d volume=%0d homing=%0b sensor_err=%0b"},
                     r.phase, r.valve_open, r.alarm_over, r.pid_setpoint, r.pid_enable,
                     r.pid_clear, r.motor_command, r.volume_command, r.homing_request,
                     r.sensor_error);
  endfunction

  // Present one beat and hold it until accepted, then log its expected result.
  // Valid stays high on return; the caller lowers it only for a gap.
  task automatic drive_beat(input vent_beat_t b, input bit typed,
                            input vent_result_t want);
    vent_result_t r;
    cmd_i          <= b.cmd;
    pressure_i     <= b.pressure;
    sensor_ok_i    <= b.sensor_ok;
    endstop_open_i <= b.endstop_open;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    r = step_model(b);
    if (typed) r = want;
    due_results.push_back(r);
    n_beats++;
    if (r.motor_command == MOT_STOP) n_stops++;
    if (r.sensor_error) n_sensor_errs++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    logic [15:0] d;
    d = value[15:0];
    // pressure registers hold 12 bits; junk above them must be dropped
    if (idx >= CFG_TARGET_PIP) d[15:PW] = (16-PW)'($urandom_range(0, 15));
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    load_setting(idx, d);
  endtask

  // Only called with the block idle: nothing in flight, no result held.
  task automatic settle(input int insp_t, input int exhale_t, input int recruit_t,
                        input int pip, input int peep, input int rpip,
                        input int alarm_lvl, input int relief_lvl);
    drain_results();
    @(posedge clk_i);
    write_reg(CFG_INSP_TICKS, insp_t);
    write_reg(CFG_EXP_TICKS, exhale_t);
    write_reg(CFG_RECRUIT_TICKS, recruit_t);
    write_reg(CFG_TARGET_PIP, pip);
    write_reg(CFG_TARGET_PEEP, peep);
    write_reg(CFG_RECRUIT_PIP, rpip);
    write_reg(CFG_ALARM_PRESSURE, alarm_lvl);
    write_reg(CFG_RELIEF_PRESSURE, relief_lvl);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Random traffic in bursts; a quarter of the burst boundaries have no gap.
  task automatic run_random(input int n_items);
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    repeat (n_items) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        idle_cycles(gap);
        burst = $urandom_range(1, 40);
      end
      drive_beat(random_beat(), 1'b0, '0);
      burst--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: stall pattern changes mode whenever its random run ends.
  // Stall runs are capped so the quiet limit holds.
  // --------------------------------------------------------------------------
  sink_mode_e sink_mode = SINK_FREE;
  int         sink_left = 0;
  int         stall_run = 0;

  always @(posedge clk_i) begin
    bit s;
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(40, 300);
    end
    sink_left--;
    case (sink_mode)
      SINK_LIGHT:    s = ($urandom_range(0, 2) == 0);
      SINK_HEAVY:    s = ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: s = ((sink_left % 4) < 2);
      default:       s = 1'b0;
    endcase
    if (s) stall_run++;
    else stall_run = 0;
    if (stall_run > 10) begin
      s         = 1'b0;
      stall_run = 0;
    end
    out_stall_i <= s;
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    vent_result_t got;
    vent_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.phase          = phase_o;
      got.valve_open     = valve_open_o;
      got.alarm_over     = alarm_over_o;
      got.pid_setpoint   = pid_setpoint_o;
      got.pid_enable     = pid_enable_o;
      got.pid_clear      = pid_clear_o;
      got.motor_command  = motor_command_o;
      got.volume_command = volume_command_o;
      got.homing_request = homing_request_o;
      got.sensor_error   = sensor_error_o;
      if (due_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%t: result beat with nothing expected: %s", $realtime, show(got));
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%t: mismatch on result %0d", $realtime, n_results);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
      n_results++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no beat moves on either channel for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t rows[$];
    int       k;

    reset_model();
    n_settings = 1;  // reset defaults
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Homing is only visited once per run, right after reset. The seed picks
    // whether it is entered normally or with a sensor fault that skips it;
    // the leave-recruitment command that follows brings both paths back to
    // the same state, so the typed rows below hold either way.
    rows.push_back(row(CMD_TICK, 0, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1));
    rows.push_back(row(CMD_RECRUIT_OFF, 0, 1'b1, 1'b0));
    // exsufflation start at reset lengths
    rows.push_back(trow(CMD_TICK, 0, 1'b1, 1'b0,
                        res(PH_EXS, 1, 0, 0, 0, 1, MOT_LOW, VOL_SAVE_RESET, 0, 0)));
    // pressure extremes: full scale trips alarm and relief, bottom closes valve
    rows.push_back(trow(CMD_TICK, 2047, 1'b1, 1'b1,
                        res(PH_EXS, 1, 1, 80, 1, 0, MOT_NONE, VOL_NONE, 0, 0)));
    rows.push_back(trow(CMD_TICK, -2048, 1'b1, 1'b0,
                        res(PH_EXS, 0, 0, 80, 1, 0, MOT_NONE, VOL_NONE, 0, 0)));
    // PEEP band edges: at low edge closes, at high edge holds, above opens
    rows.push_back(row(CMD_TICK, 72, 1'b1, 1'b0));
    rows.push_back(row(CMD_TICK, 88, 1'b1, 1'b1));
    rows.push_back(row(CMD_TICK, 89, 1'b1, 1'b0));
    rows.push_back(row(CMD_TICK, 73, 1'b1, 1'b1));
    // recruitment entry and its insufflation start
    rows.push_back(row(CMD_RECRUIT_ON, 0, 1'b1, 1'b0));
    rows.push_back(trow(CMD_TICK, 0, 1'b1, 1'b0,
                        res(PH_INS, 0, 0, 0, 0, 1, MOT_HIGH, VOL_RESET, 0, 0)));
    // recruitment band edges around 640
    rows.push_back(row(CMD_TICK, 672, 1'b1, 1'b0));
    rows.push_back(row(CMD_TICK, 673, 1'b1, 1'b1));
    rows.push_back(row(CMD_TICK, 632, 1'b1, 1'b0));
    rows.push_back(row(CMD_TICK, 631, 1'b1, 1'b1));
    // unused command code, then recruitment entered twice
    rows.push_back(row(CMD_UNUSED, 2047, 1'b0, 1'b1));
    rows.push_back(row(CMD_RECRUIT_ON, -2048, 1'b0, 1'b1));
    rows.push_back(row(CMD_TICK, 0, 1'b1, 1'b0));
    // leave recruitment, also when it is no longer active
    rows.push_back(row(CMD_RECRUIT_OFF, 0, 1'b1, 1'b0));
    rows.push_back(row(CMD_RECRUIT_OFF, 0, 1'b1, 1'b1));
    // sensor fault forces running exsufflation over the initial phase
    rows.push_back(trow(CMD_TICK, 1041, 1'b0, 1'b1,
                        res(PH_EXS, 1, 1, 80, 1, 0, MOT_NONE, VOL_NONE, 0, 1)));
    // alarm threshold: strictly above sets it, equal clears it
    rows.push_back(row(CMD_TICK, 961, 1'b1, 1'b0));
    rows.push_back(row(CMD_TICK, 960, 1'b1, 1'b0));

    for (k = 0; k < rows.size(); k++) begin
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
      drive_beat(rows[k].beat, rows[k].typed, rows[k].want);
    end

    // short cycles at nominal pressures
    settle(3, 5, 6, 320, 80, 640, 960, 1040);
    run_random(RANDOM_BEATS);
    // zero lengths: every running phase lasts one tick
    settle(0, 0, 0, any_pressure(), any_pressure(), any_pressure(),
           any_pressure(), any_pressure());
    run_random(RANDOM_BEATS);
    // realistic spread of thresholds
    settle($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
           $urandom_range(0, 800), $urandom_range(0, 200), $urandom_range(200, 900),
           $urandom_range(300, 1200), $urandom_range(300, 1400));
    run_random(RANDOM_BEATS);
    // top of range: the upper PEEP and recruitment band edges fall outside 12 bits
    settle(1, 2, 4, 2047, 2047, 2047, 2047, 2047);
    run_random(RANDOM_BEATS);
    // bottom of range
    settle(2, 1, 3, -2048, -2048, -2048, -2048, -2048);
    run_random(RANDOM_BEATS);
    settle($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
           any_pressure(), any_pressure(), any_pressure(), any_pressure(),
           any_pressure());
    run_random(RANDOM_BEATS);

    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d beats under %0d register settings: %0d results checked,",
             n_beats, n_settings, n_results);
    $display("%0d phase timeouts, %0d sensor faults, %0d mismatches",
             n_stops, n_sensor_errs, n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
